/* rtl/ssd_pkg.sv */
// Shared types and constants for the servo status packet deframer.
`timescale 1ns / 1ps

package ssd_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] LEN_MIN  = 8'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CSUM    = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_LEN     = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    PH_HUNT1 = 7'b0000001,
    PH_HUNT2 = 7'b0000010,
    PH_ID    = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_ERR   = 7'b0010000,
    PH_PARAM = 7'b0100000,
    PH_CSUM  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] param_position;
    logic [7:0] servo_id;
    logic [7:0] error_flags;
    status_t    status;
    logic       last;
  } res_item_t;

endpackage

/* rtl/ssd_in_reg.sv */
// Input register stage: holds one received beat until the parser takes it.
`timescale 1ns / 1ps

module ssd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [7:0]        in_rx_byte,
  input  logic              blocked,
  output logic              item_valid,
  output ssd_pkg::in_item_t item
);

  logic              valid_r, valid_nxt;
  ssd_pkg::in_item_t item_r;

  // hold the beat only while the result side blocks the parser
  assign in_stall  = valid_r && blocked;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.cmd     <= in_cmd;
      item_r.rx_byte <= in_rx_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* rtl/ssd_core.sv */
// Packet parser state machine: one byte or timeout event per cycle while not blocked.
`timescale 1ns / 1ps

module ssd_core #(
  parameter int MAX_PARAMS = 253
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ssd_pkg::in_item_t  item,
  output logic               res_valid,
  output ssd_pkg::res_item_t res
);

  localparam logic [8:0] LEN_MAX = 9'(MAX_PARAMS + 2);

  ssd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] err_r, err_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] b;
  logic [7:0] left_dec;
  logic       do_final;
  ssd_pkg::status_t fin_status;

  assign b        = item.rx_byte;
  assign left_dec = left_r - 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    id_nxt     = id_r;
    err_nxt    = err_r;
    left_nxt   = left_r;
    cnt_nxt    = cnt_r;
    do_final   = 1'b0;
    fin_status = ssd_pkg::ST_OK;
    res_valid  = 1'b0;
    res.data_byte      = 8'd0;
    res.param_position = 8'd0;
    res.servo_id       = id_r;
    res.error_flags    = err_r;
    res.status         = ssd_pkg::ST_OK;
    res.last           = 1'b0;

    if (fire) begin
      if (item.cmd) begin
        do_final   = 1'b1;
        fin_status = ssd_pkg::ST_TIMEOUT;
      end else begin
        case (phase_r)
          ssd_pkg::PH_HUNT2: begin
            phase_nxt = (b == ssd_pkg::HDR_BYTE) ? ssd_pkg::PH_ID : ssd_pkg::PH_HUNT1;
          end
          ssd_pkg::PH_ID: begin
            // skip extra header bytes
            if (b != ssd_pkg::HDR_BYTE) begin
              id_nxt    = b;
              sum_nxt   = b;
              phase_nxt = ssd_pkg::PH_LEN;
            end
          end
          ssd_pkg::PH_LEN: begin
            if (b < ssd_pkg::LEN_MIN || {1'b0, b} > LEN_MAX) begin
              do_final   = 1'b1;
              fin_status = ssd_pkg::ST_LEN;
              res.error_flags = 8'd0;
            end else begin
              sum_nxt   = sum_r + b;
              left_nxt  = b - ssd_pkg::LEN_MIN;
              cnt_nxt   = 8'd0;
              phase_nxt = ssd_pkg::PH_ERR;
            end
          end
          ssd_pkg::PH_ERR: begin
            err_nxt   = b;
            sum_nxt   = sum_r + b;
            phase_nxt = (left_r == 8'd0) ? ssd_pkg::PH_CSUM : ssd_pkg::PH_PARAM;
          end
          ssd_pkg::PH_PARAM: begin
            sum_nxt   = sum_r + b;
            res_valid = 1'b1;
            res.data_byte      = b;
            res.param_position = cnt_r;
            cnt_nxt   = cnt_r + 8'd1;
            left_nxt  = left_dec;
            if (left_dec == 8'd0) begin
              phase_nxt = ssd_pkg::PH_CSUM;
            end
          end
          ssd_pkg::PH_CSUM: begin
            do_final   = 1'b1;
            fin_status = (~sum_r == b) ? ssd_pkg::ST_OK : ssd_pkg::ST_CSUM;
          end
          default: begin
            phase_nxt = (b == ssd_pkg::HDR_BYTE) ? ssd_pkg::PH_HUNT2 : ssd_pkg::PH_HUNT1;
          end
        endcase
      end

      if (do_final) begin
        res_valid          = 1'b1;
        res.data_byte      = 8'd0;
        res.param_position = 8'd0;
        res.status         = fin_status;
        res.last           = 1'b1;
        // drop the packet context
        phase_nxt = ssd_pkg::PH_HUNT1;
        sum_nxt   = 8'd0;
        id_nxt    = 8'd0;
        err_nxt   = 8'd0;
        left_nxt  = 8'd0;
        cnt_nxt   = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ssd_pkg::PH_HUNT1;
      sum_r   <= 8'd0;
      id_r    <= 8'd0;
      err_r   <= 8'd0;
      left_r  <= 8'd0;
      cnt_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      id_r    <= id_nxt;
      err_r   <= err_nxt;
      left_r  <= left_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* rtl/ssd_out_reg.sv */
// Result register: holds one result beat until the receiver takes it.
`timescale 1ns / 1ps

module ssd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ssd_pkg::res_item_t res,
  output logic               blocked,
  output logic               out_valid,
  input  logic               out_stall,
  output ssd_pkg::res_item_t out_res
);

  logic               valid_r, valid_nxt;
  ssd_pkg::res_item_t res_r;

  assign blocked = valid_r && out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* rtl/servo_status_packet_deframer.sv */
// Top level of the servo bus status packet deframer.
`timescale 1ns / 1ps

// Takes one beat per clock while in_stall is low: a received bus byte
// (in_cmd = 0) or a receive timeout (in_cmd = 1). It hunts for two 0xFF
// header bytes, then reads id, length, error byte, length-2 parameter
// bytes and checksum. Every parameter byte leaves as a beat with
// out_last = 0; every packet end, bad length or timeout leaves one beat
// with out_last = 1 and the status. A beat is registered in the input
// register, then passes through the parser into the result register;
// the block sustains one beat per cycle while the result side does not
// stall. A stall on the result side holds both registers.
module servo_status_packet_deframer #(
  parameter int MAX_PARAMS = 253
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_param_position,
  output logic [7:0] out_servo_id,
  output logic [7:0] out_error_flags,
  output logic [1:0] out_status,
  output logic       out_last
);

  ssd_pkg::in_item_t  item;
  ssd_pkg::res_item_t res;
  ssd_pkg::res_item_t out_res;
  logic item_valid;
  logic blocked;
  logic fire;
  logic res_valid;

  assign fire = item_valid && !blocked;

  ssd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_rx_byte (in_rx_byte),
    .blocked    (blocked),
    .item_valid (item_valid),
    .item       (item)
  );

  ssd_core #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ssd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .blocked   (blocked),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_data_byte      = out_res.data_byte;
  assign out_param_position = out_res.param_position;
  assign out_servo_id       = out_res.servo_id;
  assign out_error_flags    = out_res.error_flags;
  assign out_status         = out_res.status;
  assign out_last           = out_res.last;

endmodule

/* rtl/ssd_checker.sv */
// Port-level checks for the servo status packet deframer, bound to the top level.
`timescale 1ns / 1ps

module ssd_port_checks #(
  parameter int MAX_PARAMS = 253
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_cmd,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_byte,
  input logic [7:0] out_param_position,
  input logic [7:0] out_servo_id,
  input logic [7:0] out_error_flags,
  input logic [1:0] out_status,
  input logic       out_last
);

  localparam logic [8:0] POS_LIMIT = 9'(MAX_PARAMS);

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte)
      && $stable(out_param_position) && $stable(out_servo_id)
      && $stable(out_error_flags) && $stable(out_status) && $stable(out_last))
    else $error("result beat changed while stalled");

  // a stalled input beat keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_cmd) && $stable(in_rx_byte))
    else $error("input beat changed while stalled");

  a_param_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ssd_pkg::ST_OK
      && {1'b0, out_param_position} < POS_LIMIT)
    else $error("parameter beat with bad status or position");

  a_final_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_data_byte == 8'd0 && out_param_position == 8'd0
      && (out_status != ssd_pkg::ST_LEN || out_error_flags == 8'd0))
    else $error("final beat carries parameter data or a stale error byte");

  a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_servo_id != ssd_pkg::HDR_BYTE)
    else $error("result beat carries a header byte as id");

endmodule

bind servo_status_packet_deframer ssd_port_checks #(.MAX_PARAMS(MAX_PARAMS))
  u_ssd_port_checks (.*);

/* sim/ssd_tb_pkg.sv */
// Stimulus codes shared by the deframer testbench and its checker.
`timescale 1ns / 1ps

package ssd_tb_pkg;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

endpackage

/* sim/ssd_checker.sv */
// Watches both channels of the deframer, predicts its results and compares them.
`timescale 1ns / 1ps

module ssd_checker #(
  parameter int MAX_PARAMS = 253
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_data_byte,
  input  logic [7:0] out_param_position,
  input  logic [7:0] out_servo_id,
  input  logic [7:0] out_error_flags,
  input  logic [1:0] out_status,
  input  logic       out_last,
  output int         fail_count,
  output int         pending_count
);

  typedef enum logic [6:0] {
    HUNT_FIRST  = 7'b0000001,
    HUNT_SECOND = 7'b0000010,
    TAKE_ID     = 7'b0000100,
    TAKE_LEN    = 7'b0001000,
    TAKE_ERR    = 7'b0010000,
    TAKE_PARAM  = 7'b0100000,
    TAKE_SUM    = 7'b1000000
  } parse_phase_t;

  parse_phase_t       parse_phase;
  logic [7:0]         sum_acc;
  logic [7:0]         cur_id;
  logic [7:0]         cur_err;
  logic [7:0]         params_remaining;
  logic [7:0]         param_idx;
  ssd_pkg::res_item_t due_results[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  function automatic void clear_parser();
    parse_phase      = HUNT_FIRST;
    sum_acc          = '0;
    cur_id           = '0;
    cur_err          = '0;
    params_remaining = '0;
    param_idx        = '0;
  endfunction

  function automatic void close_packet(input ssd_pkg::status_t st);
    ssd_pkg::res_item_t r;
    r.data_byte      = '0;
    r.param_position = '0;
    r.servo_id       = cur_id;
    r.error_flags    = cur_err;
    r.status         = st;
    r.last           = 1'b1;
    due_results.push_back(r);
    clear_parser();
  endfunction

  function automatic void deframe_beat(input logic cmd, input logic [7:0] b);
    ssd_pkg::res_item_t r;
    if (cmd == ssd_tb_pkg::CMD_TIMEOUT) begin
      close_packet(ssd_pkg::ST_TIMEOUT);
      return;
    end
    case (parse_phase)
      HUNT_SECOND: parse_phase = (b == ssd_pkg::HDR_BYTE) ? TAKE_ID : HUNT_FIRST;
      TAKE_ID: begin
        // skip surplus header bytes
        if (b != ssd_pkg::HDR_BYTE) begin
          cur_id      = b;
          sum_acc     = b;
          parse_phase = TAKE_LEN;
        end
      end
      TAKE_LEN: begin
        if (b < ssd_pkg::LEN_MIN || (int'(b) - int'(ssd_pkg::LEN_MIN)) > MAX_PARAMS) begin
          cur_err = '0;
          close_packet(ssd_pkg::ST_LEN);
        end else begin
          sum_acc          = sum_acc + b;
          params_remaining = b - ssd_pkg::LEN_MIN;
          param_idx        = '0;
          parse_phase      = TAKE_ERR;
        end
      end
      TAKE_ERR: begin
        cur_err     = b;
        sum_acc     = sum_acc + b;
        parse_phase = (params_remaining == 8'd0) ? TAKE_SUM : TAKE_PARAM;
      end
      TAKE_PARAM: begin
        sum_acc          = sum_acc + b;
        r.data_byte      = b;
        r.param_position = param_idx;
        r.servo_id       = cur_id;
        r.error_flags    = cur_err;
        r.status         = ssd_pkg::ST_OK;
        r.last           = 1'b0;
        due_results.push_back(r);
        param_idx        = param_idx + 8'd1;
        params_remaining = params_remaining - 8'd1;
        if (params_remaining == 8'd0) parse_phase = TAKE_SUM;
      end
      TAKE_SUM: close_packet((8'(~sum_acc) == b) ? ssd_pkg::ST_OK : ssd_pkg::ST_CSUM);
      default: parse_phase = (b == ssd_pkg::HDR_BYTE) ? HUNT_SECOND : HUNT_FIRST;
    endcase
  endfunction

  always @(posedge clk) begin
    ssd_pkg::res_item_t want;
    if (!rst_n) begin
      clear_parser();
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result beat", int'(out_last), 0);
        end else begin
          want = due_results.pop_front();
          if (out_data_byte !== want.data_byte)
            report_mismatch("data_byte", int'(out_data_byte), int'(want.data_byte));
          if (out_param_position !== want.param_position)
            report_mismatch("param_position", int'(out_param_position),
                            int'(want.param_position));
          if (out_servo_id !== want.servo_id)
            report_mismatch("servo_id", int'(out_servo_id), int'(want.servo_id));
          if (out_error_flags !== want.error_flags)
            report_mismatch("error_flags", int'(out_error_flags), int'(want.error_flags));
          if (out_status !== want.status)
            report_mismatch("status", int'(out_status), int'(want.status));
          if (out_last !== want.last)
            report_mismatch("last", int'(out_last), int'(want.last));
        end
      end
      if (in_valid && !in_stall) deframe_beat(in_cmd, in_rx_byte);
    end
    pending_count <= due_results.size();
  end

endmodule

/* sim/tb_top.sv */
// Top of the deframer testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int ITEMS_TARGET = 1650;
  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 80;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_cmd = ssd_tb_pkg::CMD_BYTE;
  logic [7:0] in_rx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic [7:0] out_param_position;
  logic [7:0] out_servo_id;
  logic [7:0] out_error_flags;
  logic [1:0] out_status;
  logic       out_last;

  int fail_count;
  int pending_count;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  servo_status_packet_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_byte      (out_data_byte),
    .out_param_position (out_param_position),
    .out_servo_id       (out_servo_id),
    .out_error_flags    (out_error_flags),
    .out_status         (out_status),
    .out_last           (out_last)
  );

  ssd_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_byte      (out_data_byte),
    .out_param_position (out_param_position),
    .out_servo_id       (out_servo_id),
    .out_error_flags    (out_error_flags),
    .out_status         (out_status),
    .out_last           (out_last),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  // Receiver: random stalls, or one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one beat, with random gaps ahead of it, and hold it until taken.
  task automatic send_beat(input logic cmd, input logic [7:0] b, input bit counts);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_rx_byte <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (counts) items_sent++;
  endtask

  // Send header, id, length and, for a length of at least LEN_MIN, error, params and
  // checksum; optionally cut the frame short with a timeout at beat cut_at, or corrupt the checksum.
  task automatic send_packet(input int extra_ff, input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] err, input int cut_at, input bit bad_sum);
    logic [7:0] frame[$];
    logic [7:0] sum;
    logic [7:0] p;
    int         i;
    frame = {ssd_pkg::HDR_BYTE, ssd_pkg::HDR_BYTE};
    for (i = 0; i < extra_ff; i++) frame.push_back(ssd_pkg::HDR_BYTE);
    frame.push_back(id);
    frame.push_back(len);
    if (len >= ssd_pkg::LEN_MIN) begin
      frame.push_back(err);
      sum = id + len + err;
      for (i = 0; i < int'(len) - int'(ssd_pkg::LEN_MIN); i++) begin
        p = 8'($urandom);
        frame.push_back(p);
        sum = sum + p;
      end
      sum = ~sum;
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      frame.push_back(sum);
    end
    for (i = 0; i < frame.size(); i++) begin
      if (i == cut_at) begin
        send_beat(ssd_tb_pkg::CMD_TIMEOUT, 8'($urandom), 1'b1);
        return;
      end
      send_beat(ssd_tb_pkg::CMD_BYTE, frame[i], 1'b1);
    end
  endtask

  initial begin
    int         ph;
    int         target;
    int         pick;
    int         n;
    int         k;
    logic [7:0] len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: timeouts, header mismatch, surplus headers, bad lengths,
    // bad checksum, timeout inside the parameters
    send_beat(ssd_tb_pkg::CMD_TIMEOUT, 8'h00, 1'b1);
    send_beat(ssd_tb_pkg::CMD_BYTE, 8'h00, 1'b0);
    send_beat(ssd_tb_pkg::CMD_BYTE, ssd_pkg::HDR_BYTE, 1'b0);
    send_beat(ssd_tb_pkg::CMD_BYTE, 8'h12, 1'b0);
    send_packet(2, 8'h00, ssd_pkg::LEN_MIN, 8'h00, -1, 1'b0);
    send_packet(0, 8'hFE, 8'd0, 8'hFF, -1, 1'b0);
    send_packet(0, 8'h55, 8'd1, 8'h00, -1, 1'b0);
    send_packet(0, 8'hAA, 8'd4, 8'hFF, -1, 1'b1);
    send_packet(0, 8'h01, 8'd5, 8'h80, 6, 1'b0);
    send_beat(ssd_tb_pkg::CMD_TIMEOUT, ssd_pkg::HDR_BYTE, 1'b1);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct <= 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct <= 10;
          // one full-length packet covers every parameter position
          send_packet(0, 8'($urandom_range(0, 254)), 8'd255, 8'($urandom), -1, 1'b0);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          hold_req <= 1'b1;
        end
      endcase
      target = ITEMS_TARGET * (ph + 1) / 3;
      while (items_sent < target) begin
        pick = int'($urandom_range(0, 99));
        len  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(2, 40))
                                            : 8'($urandom_range(2, 10));
        k    = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 2)) : 0;
        if (pick < 60) begin
          send_packet(k, 8'($urandom_range(0, 254)), len, 8'($urandom), -1, 1'b0);
        end else if (pick < 70) begin
          send_packet(k, 8'($urandom_range(0, 254)), len, 8'($urandom), -1, 1'b1);
        end else if (pick < 78) begin
          send_packet(k, 8'($urandom_range(0, 254)), len, 8'($urandom),
                      int'($urandom_range(0, int'(len) + 4)), 1'b0);
        end else if (pick < 84) begin
          send_packet(k, 8'($urandom_range(0, 254)), 8'($urandom_range(0, 1)),
                      8'($urandom), -1, 1'b0);
        end else if (pick < 92) begin
          // noise: stray bytes, or a lone header byte followed by a mismatch
          n = int'($urandom_range(1, 3));
          if ($urandom_range(0, 1)) send_beat(ssd_tb_pkg::CMD_BYTE, ssd_pkg::HDR_BYTE, 1'b0);
          repeat (n) send_beat(ssd_tb_pkg::CMD_BYTE, 8'($urandom_range(0, 254)), 1'b0);
        end else begin
          send_beat(ssd_tb_pkg::CMD_TIMEOUT, 8'($urandom), 1'b1);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
